// ===== design/pab_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pab_pkg: shared types and constants of the pileup allele balance block
// Character codes, base classes, register indexes and queue sizing.
// ----------------------------------------------------------------------------
package pab_pkg;

	localparam int MAX_DEPTH_DEF = 8192;
	localparam int CHAR_W        = 8;
	localparam int FIELD_W       = 14;
	localparam int FRAC_W        = 16;
	localparam int COEF_W        = 8;
	localparam int CFG_IDX_W     = 8;
	localparam int NUM_CLASSES   = 5;
	localparam int QDEPTH        = 2;
	localparam int QAW           = $clog2(QDEPTH);
	localparam int OUT_DATA_W    = 64;

	localparam logic [CFG_IDX_W-1:0] REG_SUPPORT_NUM = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPORT_DEN = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MINOR_NUM   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MINOR_DEN   = 8'd3;

	localparam logic [COEF_W-1:0] SUPPORT_NUM_RST = 8'd9;
	localparam logic [COEF_W-1:0] SUPPORT_DEN_RST = 8'd10;
	localparam logic [COEF_W-1:0] MINOR_NUM_RST   = 8'd1;
	localparam logic [COEF_W-1:0] MINOR_DEN_RST   = 8'd4;

	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UC    = 8'h43;
	localparam logic [CHAR_W-1:0] CH_UG    = 8'h47;
	localparam logic [CHAR_W-1:0] CH_UT    = 8'h54;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC    = 8'h63;
	localparam logic [CHAR_W-1:0] CH_LG    = 8'h67;
	localparam logic [CHAR_W-1:0] CH_LT    = 8'h74;

	// counter slot of each class; the back end reads slot 0 as reference
	typedef enum logic [2:0] {
		K_REF  = 3'd0,
		K_A    = 3'd1,
		K_C    = 3'd2,
		K_G    = 3'd3,
		K_T    = 3'd4,
		K_NONE = 3'd5
	} base_kind_t;

	function automatic base_kind_t pab_classify(input logic [CHAR_W-1:0] ch);
		base_kind_t k;
		case (ch) inside
			CH_DOT, CH_COMMA: k = K_REF;
			CH_UA, CH_LA:     k = K_A;
			CH_UC, CH_LC:     k = K_C;
			CH_UG, CH_LG:     k = K_G;
			CH_UT, CH_LT:     k = K_T;
			default:          k = K_NONE;
		endcase
		return k;
	endfunction

endpackage

// ===== design/pab_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pab_front: pileup character classifier and counters
// Takes one character a cycle while the queue is not full, bumps the saturating class counters and, on
// the last character of a site, pushes the final counts into the queue.
// ----------------------------------------------------------------------------
module pab_front import pab_pkg::*; #(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             in_valid,
	output logic                                             in_ready,
	input  logic [CHAR_W-1:0]                                in_char,
	input  logic                                             in_last,
	output logic                                             push,
	output logic [NUM_CLASSES-1:0][$clog2(MAX_DEPTH+1)-1:0]  push_counts,
	input  logic                                             q_full
);

	localparam int CW = $clog2(MAX_DEPTH + 1);

	logic [NUM_CLASSES-1:0][CW-1:0] cnt_q;
	logic [NUM_CLASSES-1:0][CW-1:0] cnt_next;
	base_kind_t                     kind;
	logic                           accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign kind     = pab_classify(in_char);

	always_comb begin
		for (int i = 0; i < NUM_CLASSES; i++) begin
			if (kind == base_kind_t'(3'(i)) && cnt_q[i] < CW'(MAX_DEPTH)) begin
				cnt_next[i] = cnt_q[i] + CW'(1);
			end else begin
				cnt_next[i] = cnt_q[i];
			end
		end
	end

	assign push        = accept && in_last;
	assign push_counts = cnt_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			// counts restart for the next site once this one is queued
			cnt_q <= in_last ? '0 : cnt_next;
		end
	end

endmodule

// ===== design/pab_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pab_queue: short site queue
// Holds finished site counts between the counters and the evaluator.
// ----------------------------------------------------------------------------
module pab_queue import pab_pkg::*; #(
	parameter int DW = 70
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] pop_data,
	output logic          not_empty
);

	localparam int CNTW = $clog2(QDEPTH + 1);

	logic [DW-1:0]   mem_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [CNTW-1:0] count_q;

	assign full      = count_q == CNTW'(QDEPTH);
	assign not_empty = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

endmodule

// ===== design/pab_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pab_back: site evaluator
// Picks the top alternate count, checks both balance thresholds, runs a
// bit-serial divide for the allele fraction of a passing site and holds the result.
// ----------------------------------------------------------------------------
module pab_back import pab_pkg::*; #(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             cfg_valid,
	input  logic [CFG_IDX_W-1:0]                             cfg_index,
	input  logic [COEF_W-1:0]                                cfg_data,
	input  logic                                             q_valid,
	input  logic [NUM_CLASSES-1:0][$clog2(MAX_DEPTH+1)-1:0]  q_counts,
	output logic                                             q_pop,
	output logic                                             out_valid,
	input  logic                                             out_ready,
	output logic                                             out_pass,
	output logic [OUT_DATA_W-1:0]                            out_data
);

	localparam int CW  = $clog2(MAX_DEPTH + 1);
	localparam int PRW = CW + 1 + COEF_W;
	localparam int TRW = CW + 3 + COEF_W;
	localparam int DCW = $clog2(FRAC_W);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_CMP  = 5'b00100,
		S_DIV  = 5'b01000,
		S_OUT  = 5'b10000
	} back_state_t;

	back_state_t        state_q;
	logic [COEF_W-1:0]  sup_num_q, sup_den_q, min_num_q, min_den_q;
	logic [CW-1:0]      ref_q, top_q, minor_q, base_q;
	logic [CW:0]        pair_q;
	logic [CW+2:0]      total_q;
	logic [PRW-1:0]     sup_l_q, min_r_q;
	logic [TRW-1:0]     sup_r_q;
	logic [CW+COEF_W-1:0] min_l_q;
	logic               pass_q;
	logic [CW:0]        rem_q;
	logic [FRAC_W-1:0]  quot_q;
	logic [DCW-1:0]     div_cnt_q;

	logic [CW-1:0]      top_c, max_ac, max_gt;
	logic [CW+2:0]      total_c;
	logic [CW+1:0]      rem_sh;
	logic               rem_ge;
	logic               pass_c;

	assign max_ac  = (q_counts[K_C] > q_counts[K_A]) ? q_counts[K_C] : q_counts[K_A];
	assign max_gt  = (q_counts[K_T] > q_counts[K_G]) ? q_counts[K_T] : q_counts[K_G];
	assign top_c   = (max_gt > max_ac) ? max_gt : max_ac;
	assign total_c = (CW+3)'(q_counts[K_REF]) + (CW+3)'(q_counts[K_A])
		+ (CW+3)'(q_counts[K_C]) + (CW+3)'(q_counts[K_G]) + (CW+3)'(q_counts[K_T]);

	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = rem_sh >= (CW+2)'(pair_q);
	assign pass_c = (TRW'(sup_l_q) > sup_r_q) && (PRW'(min_l_q) > min_r_q);

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign out_valid = state_q == S_OUT;
	assign out_pass  = pass_q;
	assign out_data  = {
		{(OUT_DATA_W - FRAC_W - 3 * FIELD_W){1'b0}},
		FIELD_W'(base_q), FIELD_W'(top_q), FIELD_W'(ref_q), quot_q
	};

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sup_num_q <= SUPPORT_NUM_RST;
			sup_den_q <= SUPPORT_DEN_RST;
			min_num_q <= MINOR_NUM_RST;
			min_den_q <= MINOR_DEN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SUPPORT_NUM: sup_num_q <= cfg_data;
				REG_SUPPORT_DEN: sup_den_q <= cfg_data;
				REG_MINOR_NUM:   min_num_q <= cfg_data;
				REG_MINOR_DEN:   min_den_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_CMP;
				S_CMP: begin
					div_cnt_q <= '0;
					state_q   <= pass_c ? S_DIV : S_OUT;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == DCW'(FRAC_W - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ref_q   <= q_counts[K_REF];
				top_q   <= top_c;
				pair_q  <= (CW+1)'(q_counts[K_REF]) + (CW+1)'(top_c);
				total_q <= total_c;
				minor_q <= (top_c < q_counts[K_REF]) ? top_c : q_counts[K_REF];
				base_q  <= (total_c > (CW+3)'(MAX_DEPTH)) ? CW'(MAX_DEPTH) : CW'(total_c);
			end
			S_MUL: begin
				sup_l_q <= PRW'(pair_q) * PRW'(sup_den_q);
				sup_r_q <= TRW'(total_q) * TRW'(sup_num_q);
				min_l_q <= (CW+COEF_W)'(minor_q) * (CW+COEF_W)'(min_den_q);
				min_r_q <= PRW'(pair_q) * PRW'(min_num_q);
			end
			S_CMP: begin
				pass_q <= pass_c;
				rem_q  <= (CW+1)'(top_q);
				quot_q <= '0;
			end
			S_DIV: begin
				// restoring divide, one quotient bit per cycle
				rem_q  <= rem_ge ? (CW+1)'(rem_sh - (CW+2)'(pair_q)) : (CW+1)'(rem_sh);
				quot_q <= {quot_q[FRAC_W-2:0], rem_ge};
			end
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_fail_zero_frac: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pass_q |-> quot_q == '0)
		else $error("failing site carries a nonzero fraction");

	a_pass_both_alleles: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pass_q |-> ref_q != '0 && top_q != '0)
		else $error("passing site without both alleles");

	a_counts_in_base: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> top_q <= base_q && ref_q <= base_q)
		else $error("allele count above base total");

	a_div_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_DIV |-> div_cnt_q == '0)
		else $error("divide step count left over outside divide");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == S_MUL)
		else $error("queue request taken without starting evaluation");
`endif

endmodule

// ===== design/pileup_allele_balance.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pileup_allele_balance: per-site allele balance test over pileup text
// Counts reference and per-base mismatch characters of a site and reports
// whether the site is balanced, with its alternate allele fraction.
// ----------------------------------------------------------------------------
// Usage: stream one pileup character per request on s_axis, tlast on the
// final character of a site. Characters are taken one per cycle whenever
// the two-entry site queue has room. Each site gives one result on m_axis:
// tuser holds the pass flag, tdata the fraction and the three counts.
// After the last character of a site, its counts pass through the queue and
// the evaluator's capture, multiply and compare states; a passing site also
// runs the bit-serial divide of the fraction, which sets the sustained site rate:
// sites shorter than a passing site's evaluation back up the queue and stall s_axis.
// The cfg channel writes the four threshold registers; it is always ready
// and should be used only while the block is idle.
// Reset clears all counters, the queue and the evaluator, and restores the
// default thresholds. A stalled m_axis holds its result while the counters
// keep accepting characters until the queue fills.
module pileup_allele_balance import pab_pkg::*; #(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,   // pileup_char
	input  logic                  s_axis_tlast,   // last character of site
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // allele_fraction[15:0], ref_total[29:16],
	                                              // top_alt_total[43:30], base_total[57:44]
	output logic [0:0]            m_axis_tuser,   // site_pass
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COEF_W-1:0]     cfg_data
);

	localparam int CW = $clog2(MAX_DEPTH + 1);
	localparam int DW = NUM_CLASSES * CW;

	logic                           push, q_full, q_pop, q_valid;
	logic [NUM_CLASSES-1:0][CW-1:0] push_counts, pop_counts;
	logic [DW-1:0]                  pop_flat;
	logic                           pass;

	assign cfg_ready  = 1'b1;
	assign pop_counts = pop_flat;
	assign m_axis_tuser = pass;

	pab_front #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_char     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.push        (push),
		.push_counts (push_counts),
		.q_full      (q_full)
	);

	pab_queue #(
		.DW (DW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_counts),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_flat),
		.not_empty (q_valid)
	);

	pab_back #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_counts  (pop_counts),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pass  (pass),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== tb/sv/pileup_allele_balance_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pileup_allele_balance_tb: self-checking bench of the allele balance block
// Streams pileup characters with random gaps and result back-pressure, and
// compares every site result against a cycle-free prediction of the counts,
// the two balance thresholds and the Q0.16 fraction, over several threshold
// settings, including the extremes.
// ----------------------------------------------------------------------------
module pileup_allele_balance_tb;
	import pab_pkg::*;

	localparam int SAT_DEPTH     = MAX_DEPTH_DEF;
	localparam int CYCLE_LIMIT   = 3_000_000;
	localparam int SETTLE_CYCLES = 30;
	localparam int PHASE_ITEMS   = 180;
	localparam int LONG_HOLD     = 500;
	localparam int N_PHASES      = 8;

	typedef struct packed {
		logic              pass;
		logic [FRAC_W-1:0]  frac;
		logic [FIELD_W-1:0] ref_n;
		logic [FIELD_W-1:0] top_n;
		logic [FIELD_W-1:0] base_n;
	} site_result_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              fin;
		logic              typed;
		site_result_t      want;
	} stim_row_t;

	localparam site_result_t NO_WANT = '0;

	// directed rows, default thresholds; typed results are the obvious ones
	localparam stim_row_t DIR_ROWS [25] = '{
		'{8'h00,    1'b1, 1'b1, '{1'b0, 16'h0000, 14'd0, 14'd0, 14'd0}},
		'{CH_DOT,   1'b1, 1'b1, '{1'b0, 16'h0000, 14'd1, 14'd0, 14'd1}},
		'{CH_UA,    1'b1, 1'b1, '{1'b0, 16'h0000, 14'd0, 14'd1, 14'd1}},
		'{CH_COMMA, 1'b0, 1'b0, NO_WANT},
		'{CH_LA,    1'b1, 1'b1, '{1'b1, 16'h8000, 14'd1, 14'd1, 14'd2}},
		'{CH_UC,    1'b0, 1'b0, NO_WANT},
		'{CH_LC,    1'b0, 1'b0, NO_WANT},
		'{CH_UG,    1'b0, 1'b0, NO_WANT},
		'{CH_LG,    1'b0, 1'b0, NO_WANT},
		'{CH_UT,    1'b0, 1'b0, NO_WANT},
		'{CH_LT,    1'b0, 1'b0, NO_WANT},
		'{8'hFF,    1'b0, 1'b0, NO_WANT},
		'{8'h4E,    1'b0, 1'b0, NO_WANT},
		'{8'h80,    1'b0, 1'b0, NO_WANT},
		'{CH_DOT,   1'b0, 1'b0, NO_WANT},
		'{CH_DOT,   1'b0, 1'b0, NO_WANT},
		'{CH_UT,    1'b1, 1'b0, NO_WANT},
		'{CH_DOT,   1'b0, 1'b0, NO_WANT},
		'{CH_COMMA, 1'b0, 1'b0, NO_WANT},
		'{CH_DOT,   1'b0, 1'b0, NO_WANT},
		'{CH_LG,    1'b0, 1'b0, NO_WANT},
		'{CH_UG,    1'b0, 1'b0, NO_WANT},
		'{8'h7F,    1'b0, 1'b0, NO_WANT},
		'{CH_LG,    1'b0, 1'b0, NO_WANT},
		'{CH_COMMA, 1'b1, 1'b0, NO_WANT}
	};

	// thresholds per phase as {support_num, support_den, minor_num, minor_den}
	localparam logic [31:0] PHASE_CFG [N_PHASES] = '{
		32'h00_01_00_01, 32'hFF_FF_FF_FF, 32'h09_00_01_04, 32'h01_02_01_00,
		32'h00_00_00_00, 32'h00_FF_00_FF, 32'h00_00_00_00, 32'h09_0A_01_04
	};
	localparam logic [N_PHASES-1:0] PHASE_RAND = 8'b0101_0000;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;
	logic                  s_axis_tlast  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // allele_fraction, ref_total, top_alt_total,
	                                       // base_total
	logic [0:0]            m_axis_tuser;   // site_pass
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [COEF_W-1:0]     cfg_data      = '0;

	// predictor state
	logic [FIELD_W-1:0] tally [NUM_CLASSES];
	logic [COEF_W-1:0]  sup_num, sup_den, mnr_num, mnr_den;
	site_result_t       site_q [$];

	int unsigned n_err      = 0;
	int unsigned cycles     = 0;
	int unsigned items_sent = 0;
	bit          tx_idle    = 1'b1;
	bit          rx_idle    = 1'b1;
	int          hold_req   = 0;
	int          hold_ack   = 0;
	int          stall_left = 0;

	pileup_allele_balance DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic base_kind_t kind_of(input logic [CHAR_W-1:0] ch);
		case (ch)
			CH_DOT, CH_COMMA: return K_REF;
			CH_UA, CH_LA:     return K_A;
			CH_UC, CH_LC:     return K_C;
			CH_UG, CH_LG:     return K_G;
			CH_UT, CH_LT:     return K_T;
			default:          return K_NONE;
		endcase
	endfunction

	// random spelling of a character of the given class
	function automatic logic [CHAR_W-1:0] char_of(input base_kind_t k);
		logic [CHAR_W-1:0] ch;
		bit lower;
		lower = $urandom_range(0, 1);
		case (k)
			K_REF:   ch = lower ? CH_COMMA : CH_DOT;
			K_A:     ch = lower ? CH_LA : CH_UA;
			K_C:     ch = lower ? CH_LC : CH_UC;
			K_G:     ch = lower ? CH_LG : CH_UG;
			K_T:     ch = lower ? CH_LT : CH_UT;
			default: begin
				do ch = $urandom_range(0, 255); while (kind_of(ch) != K_NONE);
			end
		endcase
		return ch;
	endfunction

	function automatic void reset_balance_model();
		sup_num = SUPPORT_NUM_RST;
		sup_den = SUPPORT_DEN_RST;
		mnr_num = MINOR_NUM_RST;
		mnr_den = MINOR_DEN_RST;
		foreach (tally[i]) tally[i] = '0;
	endfunction

	// count one character; on the last one of a site work out its verdict
	function automatic void predict_site(input logic [CHAR_W-1:0] ch, input logic fin,
	                                     output bit produced, output site_result_t r);
		base_kind_t  k;
		int          i;
		int unsigned top, refc, pair, total, minor;
		k = kind_of(ch);
		if (k != K_NONE && tally[k] < SAT_DEPTH) tally[k] = tally[k] + 1'b1;
		produced = fin;
		r = '0;
		if (!fin) return;
		refc = tally[K_REF];
		top = 0;
		total = refc;
		for (i = K_A; i <= K_T; i++) begin
			if (tally[i] > top) top = tally[i];
			total += tally[i];
		end
		pair = refc + top;
		minor = (top < refc) ? top : refc;
		// total is the plain sum of saturated counters, not clipped itself
		r.pass = (pair * sup_den > sup_num * total) && (minor * mnr_den > mnr_num * pair);
		r.frac = (r.pass && pair != 0) ? FRAC_W'((top << 16) / pair) : '0;
		r.ref_n = FIELD_W'(refc);
		r.top_n = FIELD_W'(top);
		r.base_n = FIELD_W'((total > SAT_DEPTH) ? SAT_DEPTH : total);
		foreach (tally[j]) tally[j] = '0;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
	                                    input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_err++;
		end
	endfunction

	function automatic void check_site_result();
		site_result_t w;
		if (site_q.size() == 0) begin
			$error("site result with no site pending: tdata %h", m_axis_tdata);
			n_err++;
		end else begin
			w = site_q.pop_front();
			check_field("site_pass", w.pass, m_axis_tuser[0]);
			check_field("allele_fraction", w.frac, m_axis_tdata[15:0]);
			check_field("ref_total", w.ref_n, m_axis_tdata[29:16]);
			check_field("top_alt_total", w.top_n, m_axis_tdata[43:30]);
			check_field("base_total", w.base_n, m_axis_tdata[57:44]);
			check_field("tdata padding", 32'd0, m_axis_tdata[63:58]);
		end
	endfunction

	// result side: check, then pick ready for the next cycle
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) check_site_result();
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			stall_left = LONG_HOLD;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (rx_idle) begin
			stall_left = pick_gap();
			m_axis_tready <= (stall_left == 0);
			if (stall_left > 0) stall_left--;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_char(input logic [CHAR_W-1:0] ch, input logic fin,
	                         input bit use_want, input site_result_t want);
		int           gap;
		bit           produced;
		site_result_t r;
		gap = tx_idle ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tlast <= fin;
		do @(posedge clk); while (!s_axis_tready);
		predict_site(ch, fin, produced, r);
		if (produced) site_q.push_back(use_want ? want : r);
		items_sent++;
	endtask

	// mostly plausible columns: ref plus one dominant alternate, some noise
	task automatic send_random_site();
		int         len, r, i, alt_pct, noise_pct, stray_pct;
		bit         garbage;
		base_kind_t alt, k;
		logic [CHAR_W-1:0] ch;
		r = $urandom_range(0, 99);
		len = (r < 70) ? $urandom_range(1, 12) : (r < 95) ? $urandom_range(13, 60)
		                                                 : $urandom_range(61, 200);
		garbage = ($urandom_range(0, 99) < 15);
		alt = base_kind_t'($urandom_range(K_A, K_T));
		alt_pct = $urandom_range(0, 100);
		noise_pct = $urandom_range(0, 10);
		stray_pct = $urandom_range(0, 6);
		for (i = 0; i < len; i++) begin
			if (garbage) begin
				ch = $urandom_range(0, 255);
			end else begin
				r = $urandom_range(0, 99);
				if (r < noise_pct) k = K_NONE;
				else if (r < noise_pct + stray_pct) k = base_kind_t'($urandom_range(K_A, K_T));
				else k = ($urandom_range(0, 99) < alt_pct) ? alt : K_REF;
				ch = char_of(k);
			end
			send_char(ch, i == len - 1, 1'b0, NO_WANT);
		end
	endtask

	task automatic run_sites(input int unsigned n_items);
		int unsigned start;
		start = items_sent;
		while (items_sent - start < n_items) send_random_site();
	endtask

	// deep site that drives one counter into saturation
	task automatic send_long_site(input base_kind_t main_kind, input int n_main,
	                              input base_kind_t tail_kind, input int n_tail);
		int i;
		for (i = 0; i < n_main; i++) send_char(char_of(main_kind), 1'b0, 1'b0, NO_WANT);
		for (i = 0; i < n_tail; i++)
			send_char(char_of(tail_kind), i == n_tail - 1, 1'b0, NO_WANT);
	endtask

	task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SUPPORT_NUM: sup_num = val;
			REG_SUPPORT_DEN: sup_den = val;
			REG_MINOR_NUM:   mnr_num = val;
			REG_MINOR_DEN:   mnr_den = val;
			default: ;
		endcase
	endtask

	// wait until every site result is back and the divider has gone quiet
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (site_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int          p;
		logic [31:0] cfg_word;
		reset_balance_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i])
			send_char(DIR_ROWS[i].ch, DIR_ROWS[i].fin, DIR_ROWS[i].typed, DIR_ROWS[i].want);
		run_sites(PHASE_ITEMS);

		for (p = 0; p < N_PHASES; p++) begin
			settle();
			cfg_word = PHASE_CFG[p];
			if (PHASE_RAND[p]) begin
				cfg_word[23:16] = $urandom_range(1, 255);
				cfg_word[31:24] = $urandom_range(0, cfg_word[23:16]);
				cfg_word[7:0] = $urandom_range(1, 255);
				cfg_word[15:8] = $urandom_range(0, cfg_word[7:0] / 2);
			end
			// indexes past the register file must be dropped
			write_threshold(CFG_IDX_W'($urandom_range(4, 255)), COEF_W'($urandom));
			write_threshold(REG_SUPPORT_NUM, cfg_word[31:24]);
			write_threshold(REG_SUPPORT_DEN, cfg_word[23:16]);
			write_threshold(REG_MINOR_NUM, cfg_word[15:8]);
			write_threshold(REG_MINOR_DEN, cfg_word[7:0]);
			cfg_valid <= 1'b0;

			tx_idle = (p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
			rx_idle <= ($urandom_range(0, 3) != 0);
			// long result stall while short sites keep coming, so the queue fills
			if (p == 0) hold_req <= hold_req + 1;
			run_sites(PHASE_ITEMS);

			if (p == 0 || p == N_PHASES - 1) begin
				tx_idle = 1'b0;
				if (p == 0) send_long_site(K_REF, SAT_DEPTH + 3, K_T, 40);
				else send_long_site(K_G, SAT_DEPTH + 8, K_REF, 3000);
			end
		end

		settle();
		if (n_err == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
